// ===== hw/rtl/rgd_pkg.sv =====
// ----------------------------------------------------------------------------
// rgd_pkg
// Shared constants for the RGB to gray decimator: pixel format codes, luma
// weights, the reciprocal used for the divide by 100, and size limits.
// ----------------------------------------------------------------------------
package rgd_pkg;

    // Source pixel format codes (code 3 behaves as gray8)
    localparam logic [1:0] FMT_GRAY8  = 2'd0;
    localparam logic [1:0] FMT_RGB565 = 2'd1;
    localparam logic [1:0] FMT_RGB888 = 2'd2;

    // Decimation factor code that keeps every pixel; any other code acts as 2
    localparam logic [1:0] DECIM_FULL = 2'd1;

    // Configuration register indexes
    localparam logic [1:0] REG_COLOR_FORMAT  = 2'd0;
    localparam logic [1:0] REG_DECIMATE_BY   = 2'd1;
    localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd2;
    localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd3;

    // Reset values of the configuration registers
    localparam logic [1:0]  RST_COLOR_FORMAT  = 2'd1;
    localparam logic [1:0]  RST_DECIMATE_BY   = 2'd2;
    localparam logic [12:0] RST_SOURCE_WIDTH  = 13'd640;
    localparam logic [12:0] RST_SOURCE_HEIGHT = 13'd480;

    // Largest source size; larger register values saturate to it
    localparam logic [12:0] SIZE_MAX = 13'd4096;

    // Luma weights, in percent
    localparam logic [6:0] W_RED   = 7'd30;
    localparam logic [6:0] W_GREEN = 7'd59;
    localparam logic [6:0] W_BLUE  = 7'd11;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x <= 25500
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    // Weighted channel sum before the divide
    typedef logic [14:0] luma_sum_t;

endpackage

// ===== hw/rtl/rgb_gray_decimator_top.sv =====
// ----------------------------------------------------------------------------
// rgb_gray_decimator_top
// Converts a raster pixel stream (gray8, RGB565 or RGB888) to 8-bit luma and
// keeps every pixel or every second column and row, capped to an output frame.
// ----------------------------------------------------------------------------
// The block takes one source pixel per clock and gives at most one gray
// pixel per clock as long as the master side accepts results. A kept pixel
// passes three registers on its way out: the input register that
// also holds the keep decision, the register after the constant-weight
// multiply and add of the color channels, and the output register after the
// reciprocal multiply that divides by 100. The
// column and row counters advance on every input transfer, and discarded
// pixels produce no result. Each stage holds while its successor is full, so
// the input side keeps taking pixels while a finished result waits, as long
// as a free stage remains. Configuration writes take effect at once and are
// meant for idle periods.
module rgb_gray_decimator_top
    import rgd_pkg::*;
#(
    parameter int MAX_OUT_WIDTH  = 320,
    parameter int MAX_OUT_HEIGHT = 240
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_wdata,
    // Source pixel stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] pixel_word
    input  logic        s_tuser,   // [0] start_of_frame
    // Gray pixel stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] gray, [16:8] out_column,
                                   // [24:17] out_row, [31:25] zero
    output logic        m_tlast    // last_of_frame
);

    localparam logic [12:0] MAX_W = 13'(MAX_OUT_WIDTH);
    localparam logic [12:0] MAX_H = 13'(MAX_OUT_HEIGHT);

    // Configuration registers
    logic [1:0]  color_format_reg;
    logic [1:0]  decimate_by_reg;
    logic [12:0] source_width_reg;
    logic [12:0] source_height_reg;

    // Position counters
    logic [11:0] column_reg, column_next;
    logic [11:0] row_reg, row_next;

    // Stage 0: input register with keep decision
    logic        s0_valid_reg;
    logic [23:0] s0_word_reg;
    logic [1:0]  s0_fmt_reg;
    logic [8:0]  s0_col_reg;
    logic [7:0]  s0_row_reg;
    logic        s0_last_reg;

    // Stage 1: weighted channel sum
    logic        s1_valid_reg;
    luma_sum_t   s1_sum_reg;
    logic        s1_pass_reg;
    logic [8:0]  s1_col_reg;
    logic [7:0]  s1_row_reg;
    logic        s1_last_reg;

    // Output register
    logic        out_valid_reg;
    logic [7:0]  out_gray_reg;
    logic [8:0]  out_col_reg;
    logic [7:0]  out_row_reg;
    logic        out_last_reg;

    logic s_xfer, adv_out, adv1, adv0;

    // Stage advance: a stage moves when its successor is empty or moves
    assign adv_out  = !out_valid_reg || m_tready;
    assign adv1     = !s1_valid_reg || adv_out;
    assign adv0     = !s0_valid_reg || adv1;
    assign s_tready = adv0;
    assign s_xfer   = s_tvalid && s_tready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_format_reg  <= RST_COLOR_FORMAT;
            decimate_by_reg   <= RST_DECIMATE_BY;
            source_width_reg  <= RST_SOURCE_WIDTH;
            source_height_reg <= RST_SOURCE_HEIGHT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COLOR_FORMAT:  color_format_reg  <= cfg_wdata[1:0];
                REG_DECIMATE_BY:   decimate_by_reg   <= cfg_wdata[1:0];
                REG_SOURCE_WIDTH:  source_width_reg  <= cfg_wdata;
                REG_SOURCE_HEIGHT: source_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Frame geometry and keep decision for the pixel in transfer
    logic        by_two;
    logic [12:0] width_eff, height_eff, out_w, out_h;
    logic [11:0] cur_col, cur_row;
    logic [12:0] out_c, out_r;
    logic        keep, last;

    always_comb begin
        by_two = (decimate_by_reg != DECIM_FULL);

        if (source_width_reg == 13'd0)        width_eff = 13'd1;
        else if (source_width_reg > SIZE_MAX) width_eff = SIZE_MAX;
        else                                  width_eff = source_width_reg;

        if (source_height_reg == 13'd0)        height_eff = 13'd1;
        else if (source_height_reg > SIZE_MAX) height_eff = SIZE_MAX;
        else                                   height_eff = source_height_reg;

        out_w = by_two ? (width_eff >> 1)  : width_eff;
        out_h = by_two ? (height_eff >> 1) : height_eff;
        if (out_w > MAX_W) out_w = MAX_W;
        if (out_h > MAX_H) out_h = MAX_H;

        cur_col = s_tuser ? 12'd0 : column_reg;
        cur_row = s_tuser ? 12'd0 : row_reg;

        out_c = by_two ? {2'b00, cur_col[11:1]} : {1'b0, cur_col};
        out_r = by_two ? {2'b00, cur_row[11:1]} : {1'b0, cur_row};

        keep = (!by_two || (!cur_col[0] && !cur_row[0]))
               && (out_c < out_w) && (out_r < out_h);
        last = (out_c + 13'd1 == out_w) && (out_r + 13'd1 == out_h);

        // Advance position: wrap column at width, row at height
        if ({1'b0, cur_col} + 13'd1 >= width_eff) begin
            column_next = 12'd0;
            row_next = ({1'b0, cur_row} + 13'd1 >= height_eff) ? 12'd0
                                                               : cur_row + 12'd1;
        end else begin
            column_next = cur_col + 12'd1;
            row_next    = cur_row;
        end
    end

    // Control state: counters and stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg    <= '0;
            row_reg       <= '0;
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                column_reg <= column_next;
                row_reg    <= row_next;
            end
            if (adv0)    s0_valid_reg  <= s_xfer && keep;
            if (adv1)    s1_valid_reg  <= s0_valid_reg;
            if (adv_out) out_valid_reg <= s1_valid_reg;
        end
    end

    // Stage 1 channel extraction and weighted sum
    logic [7:0] red, green, blue;
    luma_sum_t  sum_next;
    logic       pass_next;

    always_comb begin
        red       = s0_word_reg[7:0];
        green     = s0_word_reg[15:8];
        blue      = s0_word_reg[23:16];
        pass_next = 1'b0;
        case (s0_fmt_reg)
            FMT_RGB565: begin
                red   = {s0_word_reg[15:11], 3'b000};
                green = {s0_word_reg[10:5], 2'b00};
                blue  = {s0_word_reg[4:0], 3'b000};
            end
            FMT_RGB888: ;
            default: begin
                pass_next = 1'b1;
            end
        endcase
        if (pass_next) begin
            sum_next = {7'd0, s0_word_reg[7:0]};
        end else begin
            sum_next = 15'(red * W_RED) + 15'(green * W_GREEN) + 15'(blue * W_BLUE);
        end
    end

    // Divide by 100 through the reciprocal
    logic [27:0] quot_prod;
    logic [7:0]  gray_next;

    assign quot_prod = 28'(s1_sum_reg * RECIP_100);
    assign gray_next = s1_pass_reg ? s1_sum_reg[7:0]
                                   : quot_prod[RECIP_SHIFT +: 8];

    // Payload registers
    always_ff @(posedge aclk) begin
        if (adv0) begin
            s0_word_reg <= s_tdata;
            s0_fmt_reg  <= color_format_reg;
            s0_col_reg  <= out_c[8:0];
            s0_row_reg  <= out_r[7:0];
            s0_last_reg <= last;
        end
        if (adv1) begin
            s1_sum_reg  <= sum_next;
            s1_pass_reg <= pass_next;
            s1_col_reg  <= s0_col_reg;
            s1_row_reg  <= s0_row_reg;
            s1_last_reg <= s0_last_reg;
        end
        if (adv_out) begin
            out_gray_reg <= gray_next;
            out_col_reg  <= s1_col_reg;
            out_row_reg  <= s1_row_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_row_reg, out_col_reg, out_gray_reg};
    assign m_tlast  = out_last_reg;

    // Checks
    a_s0_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s0_valid_reg && !adv1) |=> (s0_valid_reg && $stable(s0_col_reg)
                                     && $stable(s0_row_reg)))
        else $error("stage 0 lost or changed a stalled pixel");

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !adv_out) |=> (s1_valid_reg && $stable(s1_sum_reg)))
        else $error("stage 1 lost or changed a stalled sum");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ({4'd0, out_col_reg} < MAX_W || MAX_W > 13'd511))
        else $error("output column beyond output frame width");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ({5'd0, out_row_reg} < MAX_H || MAX_H > 13'd255))
        else $error("output row beyond output frame height");

endmodule
